/* design/itp_pkg.sv */
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef logic [2:0] op_code_t;
    localparam op_code_t CODE_ADD    = 3'd0;
    localparam op_code_t CODE_SUB    = 3'd1;
    localparam op_code_t CODE_MUL    = 3'd2;
    localparam op_code_t CODE_DIV    = 3'd3;
    localparam op_code_t CODE_LPAREN = 3'd4;

    typedef logic [1:0] item_kind_t;
    localparam item_kind_t KIND_IDENT     = 2'd0;
    localparam item_kind_t KIND_TOKEN_END = 2'd1;
    localparam item_kind_t KIND_SYMBOL    = 2'd2;
    localparam item_kind_t KIND_EXPR_END  = 2'd3;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_IDENT,
        CLS_OP,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OTHER,
        CLS_END
    } char_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOKEN,
        ST_POP,
        ST_TAIL,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } in_word_t;

    typedef struct packed {
        item_kind_t item_kind;
        logic [7:0] symbol;
        logic       stack_overflow;
        logic       last_of_run;
    } out_word_t;

    function automatic char_class_t classify(input logic [7:0] c, input logic is_end);
        char_class_t cls;
        if (is_end) begin
            cls = CLS_END;
        end else if (c inside {8'h20, [8'h09:8'h0D]}) begin
            cls = CLS_SPACE;
        end else if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDERSCORE}) begin
            cls = CLS_IDENT;
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
            cls = CLS_OP;
        end else if (c == CH_LPAREN) begin
            cls = CLS_LPAREN;
        end else if (c == CH_RPAREN) begin
            cls = CLS_RPAREN;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic op_code_t op_code(input logic [7:0] c);
        op_code_t code;
        case (c)
            CH_PLUS:   code = CODE_ADD;
            CH_MINUS:  code = CODE_SUB;
            CH_STAR:   code = CODE_MUL;
            CH_SLASH:  code = CODE_DIV;
            CH_LPAREN: code = CODE_LPAREN;
            default:   code = CODE_ADD;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t code);
        logic [7:0] ch;
        case (code)
            CODE_ADD:    ch = CH_PLUS;
            CODE_SUB:    ch = CH_MINUS;
            CODE_MUL:    ch = CH_STAR;
            CODE_DIV:    ch = CH_SLASH;
            CODE_LPAREN: ch = CH_LPAREN;
            default:     ch = CH_PLUS;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] code_prec(input op_code_t code);
        logic [1:0] prec;
        case (code)
            CODE_ADD, CODE_SUB: prec = 2'd1;
            CODE_MUL, CODE_DIV: prec = 2'd2;
            default:            prec = 2'd0;
        endcase
        return prec;
    endfunction

endpackage

/* design/itp_stack_mem.sv */
module itp_stack_mem #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  itp_pkg::op_code_t wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output itp_pkg::op_code_t rdata
);
    import itp_pkg::*;

    op_code_t mem [STACK_DEPTH];
    op_code_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/itp_ctrl.sv */
module itp_ctrl #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  itp_pkg::in_word_t  start_word,
    output logic               busy,
    input  logic               emit_ready,
    output logic               emit_valid,
    output itp_pkg::out_word_t emit_word
);
    import itp_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

    seq_state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic        tokp_reg, tokp_next;
    logic        pend_v_reg, pend_v_next;
    out_word_t   pend_reg, pend_next;
    op_code_t    top_reg, top_next;
    logic        fresh_reg, fresh_next;
    char_class_t cls_reg;
    op_code_t    code_reg;
    logic [7:0]  char_reg;

    logic        slot_ok;
    logic        new_req;
    out_word_t   new_item;
    op_code_t    top_cur;
    logic        count_nz;
    logic        pop_cond;
    logic        mem_we;
    logic        mem_re;
    logic [CNT_W-1:0] raddr_full;
    logic [ADDR_W-1:0] mem_raddr;
    op_code_t    mem_rdata;

    itp_stack_mem #(
        .STACK_DEPTH(STACK_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_stack (
        .clk  (clk),
        .we   (mem_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(code_reg),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Top of stack comes from the memory the cycle after a pop read.
    assign top_cur    = fresh_reg ? mem_rdata : top_reg;
    assign count_nz   = (count_reg != '0);
    assign slot_ok    = !pend_v_reg || emit_ready;
    assign busy       = (state_reg != ST_IDLE);
    assign raddr_full = count_reg - CNT_TWO;
    assign mem_raddr  = raddr_full[ADDR_W-1:0];

    always_comb
    begin
        case (cls_reg)
            CLS_END:    pop_cond = count_nz;
            CLS_OP:     pop_cond = count_nz && (code_prec(top_cur) >= code_prec(code_reg));
            CLS_RPAREN: pop_cond = count_nz && (top_cur != CODE_LPAREN);
            default:    pop_cond = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            tokp_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            fresh_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            tokp_reg   <= tokp_next;
            pend_v_reg <= pend_v_next;
            fresh_reg  <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        top_reg  <= top_next;
        if (start)
        begin
            cls_reg  <= classify(start_word.char_code, start_word.is_end);
            code_reg <= op_code(start_word.char_code);
            char_reg <= start_word.char_code;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tokp_next   = tokp_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        top_next    = top_cur;
        fresh_next  = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        new_req     = 1'b0;
        new_item    = '{item_kind: KIND_SYMBOL, symbol: 8'h00,
                        stack_overflow: 1'b0, last_of_run: 1'b0};
        emit_valid  = 1'b0;
        emit_word   = pend_reg;
        emit_word.last_of_run = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_TOKEN;
                end
            end
            ST_TOKEN:
            begin
                if (cls_reg == CLS_IDENT)
                begin
                    if (slot_ok)
                    begin
                        new_req            = 1'b1;
                        new_item.item_kind = KIND_IDENT;
                        new_item.symbol    = char_reg;
                        tokp_next          = 1'b1;
                        state_next         = ST_DONE;
                    end
                end
                else if (cls_reg == CLS_SPACE)
                begin
                    state_next = ST_DONE;
                end
                else if (tokp_reg)
                begin
                    if (slot_ok)
                    begin
                        new_req            = 1'b1;
                        new_item.item_kind = KIND_TOKEN_END;
                        tokp_next          = 1'b0;
                        state_next         = ST_POP;
                    end
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!pop_cond)
                begin
                    state_next = ST_TAIL;
                end
                else if (slot_ok)
                begin
                    new_req            = 1'b1;
                    new_item.item_kind = KIND_SYMBOL;
                    new_item.symbol    = code_char(top_cur);
                    count_next         = count_reg - CNT_ONE;
                    // fetch the entry below for the next compare
                    mem_re             = (count_reg >= CNT_TWO);
                    fresh_next         = mem_re;
                end
            end
            ST_TAIL:
            begin
                case (cls_reg)
                    CLS_OP, CLS_LPAREN:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            // drop the push and flag the held word, or hold a new flagged word if none is held
                            if (pend_v_reg)
                            begin
                                pend_next.stack_overflow = 1'b1;
                            end
                            else
                            begin
                                pend_v_next = 1'b1;
                                pend_next   = '{item_kind: KIND_SYMBOL, symbol: 8'h00,
                                                stack_overflow: 1'b1, last_of_run: 1'b0};
                            end
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_ONE;
                            top_next   = code_reg;
                        end
                        state_next = ST_DONE;
                    end
                    CLS_RPAREN:
                    begin
                        if (count_nz)
                        begin
                            count_next = count_reg - CNT_ONE;
                            mem_re     = (count_reg >= CNT_TWO);
                            fresh_next = mem_re;
                        end
                        state_next = ST_DONE;
                    end
                    CLS_END:
                    begin
                        if (slot_ok)
                        begin
                            new_req            = 1'b1;
                            new_item.item_kind = KIND_EXPR_END;
                            state_next         = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (slot_ok)
                begin
                    emit_valid            = pend_v_reg;
                    emit_word.last_of_run = 1'b1;
                    pend_v_next           = 1'b0;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the held word on once the next one exists
        if (new_req)
        begin
            emit_valid  = pend_v_reg;
            pend_next   = new_item;
            pend_v_next = 1'b1;
        end
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_v_reg)
        else $error("held word left over at idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stack count above depth");

    a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> emit_ready)
        else $error("word emitted into a full output stage");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && pop_cond && slot_ok)
        |=> count_reg == $past(count_reg) - CNT_ONE)
        else $error("pop did not lower the stack count");

endmodule

/* design/infix_to_postfix_converter_top.sv */
// Channel  Direction  Handshake            Word
// char     sink       char_valid/stall     itp_pkg::in_word_t  (char_code, is_end)
// item     source     item_valid/stall     itp_pkg::out_word_t (kind, symbol, flags)
//
// One character at a time: an identifier character or whitespace passes through the token
// and done states; any other character or the end marker passes through token, pop, tail
// and done, repeating pop for each popped stack entry. The stack sits in a synchronous RAM
// whose read of the next entry overlaps the pop, so pops run back to back unless stalled.
// Reset clears the stack count, the pending-identifier flag and the sequencer;
// the stack RAM is not cleared. A stall on the item side holds the sequencer;
// char_stall is high whenever a character is in flight.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  itp_pkg::in_word_t  char_word,
    output logic               item_valid,
    input  logic               item_stall,
    output itp_pkg::out_word_t item_word
);
    import itp_pkg::*;

    logic      busy;
    logic      start;
    logic      emit_ready;
    logic      emit_valid;
    out_word_t emit_word;
    logic      item_valid_reg;
    out_word_t item_word_reg;

    assign char_stall = busy;
    assign start      = char_valid && !busy;
    assign emit_ready = !item_valid_reg || !item_stall;

    itp_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .start_word(char_word),
        .busy      (busy),
        .emit_ready(emit_ready),
        .emit_valid(emit_valid),
        .emit_word (emit_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            item_word_reg <= emit_word;
        end
    end

    assign item_valid = item_valid_reg;
    assign item_word  = item_word_reg;

endmodule
